// File: rtl/core/rscb_pkg.sv
// shared constants and types for the rolling sum chunk boundary block
`timescale 1ns / 1ps

package rscb_pkg;

  // window geometry
  localparam int WINDOW_SIZE = 8196;
  localparam int ADDR_W      = $clog2(WINDOW_SIZE);
  localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);

  // field widths
  localparam int BYTE_W = 8;
  localparam int SUM_W  = 22;
  localparam int LIM_W  = 24;
  localparam int LEN_W  = 25;
  localparam int IDX_W  = 2;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // register reset values
  localparam logic [LIM_W-1:0] MIN_BLOCK_RST = LIM_W'(256 * 1024);
  localparam logic [LIM_W-1:0] MAX_BLOCK_RST = LIM_W'(8 * 1024 * 1024);
  localparam logic [SUM_W-1:0] MASK_RST      = SUM_W'(32'h0001_FFFF);

  // register indexes
  localparam logic [IDX_W-1:0] REG_MIN_BLOCK = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_BLOCK = 2'd1;
  localparam logic [IDX_W-1:0] REG_MASK      = 2'd2;

  // item commands
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  // why a block was closed
  typedef enum logic [1:0] {
    REASON_CONTENT = 2'd0,
    REASON_FORCED  = 2'd1,
    REASON_EOS     = 2'd2
  } end_reason_t;

  // window state seen by the byte that was just written
  typedef struct packed {
    logic was_full;   // window held WINDOW_SIZE bytes before this byte
    logic full_now;   // window holds WINDOW_SIZE bytes after this byte
  } win_status_t;

endpackage

// File: rtl/core/rscb_window.sv
// window memory with write pointer and fill count
`timescale 1ns / 1ps

module rscb_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic                      cmd,
  input  logic [rscb_pkg::BYTE_W-1:0] data_byte,
  output logic [rscb_pkg::BYTE_W-1:0] leaving_r,
  output rscb_pkg::win_status_t     status_r
);

  logic [rscb_pkg::BYTE_W-1:0] mem [rscb_pkg::WINDOW_SIZE];

  logic [rscb_pkg::ADDR_W-1:0] wp_r, wp_nxt;
  logic [rscb_pkg::FILL_W-1:0] fill_r, fill_nxt;
  rscb_pkg::win_status_t       status_nxt;
  logic                        was_full;
  logic                        byte_en;

  assign byte_en  = wr_en && (cmd == rscb_pkg::CMD_DATA);
  assign was_full = (fill_r == rscb_pkg::FILL_W'(rscb_pkg::WINDOW_SIZE));

  // pointer wrap, saturating fill, restart on end of stream
  always_comb begin
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    status_nxt = status_r;
    if (wr_en) begin
      if (cmd == rscb_pkg::CMD_EOS) begin
        wp_nxt     = '0;
        fill_nxt   = '0;
        status_nxt = '0;
      end else begin
        wp_nxt = (wp_r == rscb_pkg::ADDR_W'(rscb_pkg::WINDOW_SIZE - 1)) ? '0 : wp_r + 1'b1;
        fill_nxt = was_full ? fill_r : fill_r + 1'b1;
        status_nxt.was_full = was_full;
        status_nxt.full_now = was_full ||
            (fill_r == rscb_pkg::FILL_W'(rscb_pkg::WINDOW_SIZE - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      fill_r   <= '0;
      status_r <= '0;
    end else begin
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      status_r <= status_nxt;
    end
  end

  // read-first port: the old byte leaves as the new one is stored
  always_ff @(posedge clk) begin
    if (byte_en) begin
      leaving_r <= mem[wp_r];
      mem[wp_r] <= data_byte;
    end
  end

endmodule

// File: rtl/core/rolling_sum_chunk_boundary.sv
// top level of the content-defined chunker over a moving window sum
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   in_cmd, in_data_byte
//  out_     output     out_valid / out_stall out_block_length, out_end_reason
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle unless a stalled output raises in_stall; the window memory is read and written once per byte
// a result is computed from the sum stage registers and held in the output register
// with the output stalled, one more item is taken into the sum stage, then in_stall rises
// synchronous active-low reset; the window memory is not cleared, entries are
// only used in the sum after the current stream has written them
`timescale 1ns / 1ps

module rolling_sum_chunk_boundary (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [rscb_pkg::BYTE_W-1:0] in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rscb_pkg::LEN_W-1:0]  out_block_length,
  output logic [1:0]                  out_end_reason,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rscb_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rscb_pkg::LIM_W-1:0]  cfg_data
);

  // configuration registers
  logic [rscb_pkg::LIM_W-1:0] min_r, max_r;
  logic [rscb_pkg::SUM_W-1:0] mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= rscb_pkg::MIN_BLOCK_RST;
      max_r  <= rscb_pkg::MAX_BLOCK_RST;
      mask_r <= rscb_pkg::MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        rscb_pkg::REG_MIN_BLOCK: min_r  <= cfg_data;
        rscb_pkg::REG_MAX_BLOCK: max_r  <= cfg_data;
        rscb_pkg::REG_MASK:      mask_r <= cfg_data[rscb_pkg::SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // input transfer and window access
  logic                        in_xfer;
  logic                        s1_adv;
  logic                        s1_valid_r, s1_valid_nxt;
  logic                        s1_cmd_r;
  logic [rscb_pkg::BYTE_W-1:0] s1_byte_r;
  logic [rscb_pkg::BYTE_W-1:0] leaving;
  rscb_pkg::win_status_t       win_st;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  rscb_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_xfer),
    .cmd       (in_cmd),
    .data_byte (in_data_byte),
    .leaving_r (leaving),
    .status_r  (win_st)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= in_cmd;
      s1_byte_r <= in_data_byte;
    end
  end

  // sum stage: window sum, block length and cut decision
  logic [rscb_pkg::SUM_W-1:0] sum_r, sum_nxt, sum_calc;
  logic [rscb_pkg::LEN_W-1:0] len_r, len_nxt, len_inc;
  logic                       dirty_r, dirty_nxt;
  logic                       content, forced, cut;
  logic                       s1_fire;

  assign s1_fire = s1_valid_r && s1_adv;

  always_comb begin
    sum_calc = sum_r + rscb_pkg::SUM_W'(s1_byte_r)
             - (win_st.was_full ? rscb_pkg::SUM_W'(leaving) : '0);
    len_inc  = (len_r == rscb_pkg::LEN_MAX) ? len_r : len_r + 1'b1;
    content  = ((sum_calc & mask_r) == '0);
    forced   = (len_inc > {1'b0, max_r});
    cut      = win_st.full_now && (len_inc > {1'b0, min_r}) && (content || forced);
  end

  always_comb begin
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    dirty_nxt = dirty_r;
    if (s1_fire) begin
      if (s1_cmd_r == rscb_pkg::CMD_EOS) begin
        sum_nxt   = '0;
        len_nxt   = '0;
        dirty_nxt = 1'b1;
      end else begin
        sum_nxt   = sum_calc;
        len_nxt   = cut ? '0 : len_inc;
        dirty_nxt = !cut;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      len_r   <= '0;
      dirty_r <= 1'b1;
    end else begin
      sum_r   <= sum_nxt;
      len_r   <= len_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  // output register
  logic                       res_valid;
  logic [rscb_pkg::LEN_W-1:0] res_len;
  rscb_pkg::end_reason_t      res_reason;
  logic                       out_valid_r, out_valid_nxt;
  logic [rscb_pkg::LEN_W-1:0] out_len_r;
  rscb_pkg::end_reason_t      out_reason_r;

  always_comb begin
    if (s1_cmd_r == rscb_pkg::CMD_EOS) begin
      res_valid  = dirty_r;
      res_len    = len_r;
      res_reason = rscb_pkg::REASON_EOS;
    end else begin
      res_valid  = cut;
      res_len    = len_inc;
      res_reason = content ? rscb_pkg::REASON_CONTENT : rscb_pkg::REASON_FORCED;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = res_valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      out_len_r    <= res_len;
      out_reason_r <= res_reason;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_length = out_len_r;
  assign out_end_reason   = out_reason_r;

  // checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with an empty sum stage");

  a_cut_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_end_reason != rscb_pkg::REASON_EOS) |-> out_block_length != '0)
    else $error("content or forced cut with zero length");

  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_cmd_r == rscb_pkg::CMD_EOS) |=> (len_r == '0) && (sum_r == '0) && dirty_r)
    else $error("stream state not restarted after end of stream");

  a_cut_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_cmd_r == rscb_pkg::CMD_DATA) && cut |=> !dirty_r && (len_r == '0))
    else $error("block state not cleared after a cut");

endmodule
